// ===== design/mlft_pkg.sv =====
// Package for the two-point modular line recovery block: types, codes and defaults.
`default_nettype none
package mlft_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int DATA_W         = 32;
    localparam int PADDR_W        = 3;

    localparam logic [PADDR_W-1:0] ADDR_MODULUS = 3'd0;
    localparam logic [DATA_W-1:0]  MODULUS_RST  = 32'd257;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_X_EQUAL  = 2'd1;
    localparam logic [1:0] ST_NO_SLOPE = 2'd2;

    typedef enum logic {
        OP_DIV,
        OP_MULMOD
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

endpackage
`default_nettype wire

// ===== design/mlft_pt_if.sv =====
// Input channel: one pair of share points.
`default_nettype none
interface mlft_pt_if;
    logic        valid;
    logic        ready;
    logic [31:0] x_first;
    logic [31:0] y_first;
    logic [31:0] x_second;
    logic [31:0] y_second;

    modport source (output valid, x_first, y_first, x_second, y_second, input ready);
    modport sink   (input valid, x_first, y_first, x_second, y_second, output ready);
endinterface
`default_nettype wire

// ===== design/mlft_res_if.sv =====
// Output channel: recovered slope, intercept and status.
`default_nettype none
interface mlft_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] slope;
    logic [31:0] intercept;
    logic [1:0]  status;

    modport source (output valid, slope, intercept, status, input ready);
    modport sink   (input valid, slope, intercept, status, output ready);
endinterface
`default_nettype wire

// ===== design/mlft_alu.sv =====
// Shared iterative unit: restoring divide (quotient, remainder) and modular multiply.
`default_nettype none
module mlft_alu #(
    parameter int W = mlft_pkg::VALUE_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mlft_pkg::t_alu_req i_req,
    input  wire logic [W-1:0]      i_a,
    input  wire logic [W-1:0]      i_b,
    input  wire logic [W-1:0]      i_n,
    output logic                   o_done,
    output logic [W-1:0]           o_quo,
    output logic [W-1:0]           o_rem
);
    localparam int CW = $clog2(W);

    logic              r_busy;
    logic              r_done;
    logic              r_phase;
    mlft_pkg::t_alu_op r_op;
    logic [CW-1:0]     r_cnt;
    logic [W-1:0]      r_a;
    logic [W-1:0]      r_b;
    logic [W-1:0]      r_n;
    logic [W-1:0]      r_acc;

    logic [W:0] lhs;
    logic [W:0] sub;
    logic [W:0] diff;
    logic       take;

    // one compare-subtract serves every step
    always_comb begin
        unique case (r_op)
            mlft_pkg::OP_DIV: begin
                lhs = {r_acc, r_a[W-1]};
                sub = {1'b0, r_b};
            end
            mlft_pkg::OP_MULMOD: begin
                lhs = r_phase ? ({1'b0, r_acc} + {1'b0, r_b}) : {r_acc, 1'b0};
                sub = {1'b0, r_n};
            end
            default: begin
                lhs = '0;
                sub = '0;
            end
        endcase
        diff = lhs - sub;
        take = !diff[W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_op    <= i_req.op;
                r_phase <= 1'b0;
                r_cnt   <= CW'(W - 1);
                r_a     <= i_a;
                r_b     <= i_b;
                r_n     <= i_n;
                r_acc   <= '0;
            end else if (r_busy) begin
                if (r_op == mlft_pkg::OP_DIV) begin
                    r_acc <= take ? diff[W-1:0] : lhs[W-1:0];
                    r_a   <= {r_a[W-2:0], take};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else if (!r_phase) begin
                    r_acc   <= take ? diff[W-1:0] : lhs[W-1:0];
                    r_phase <= 1'b1;
                end else begin
                    // add the multiplicand only where the multiplier bit is set
                    if (r_a[W-1]) begin
                        r_acc <= take ? diff[W-1:0] : lhs[W-1:0];
                    end
                    r_a     <= {r_a[W-2:0], 1'b0};
                    r_phase <= 1'b0;
                    r_cnt   <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_a;
    assign o_rem  = r_acc;
endmodule
`default_nettype wire

// ===== design/modular_line_from_two_points.sv =====
// Top level: recovers slope and intercept of a line through two points modulo a modulus.
// The run time is data dependent: a modulus below two goes straight to the result; otherwise
// 4 reductions, one extended Euclid round per quotient (a divide and a modular multiply, at
// most about 1.44*W rounds), then at most three more divides and two modular multiplies.
// One item at a time: input ready only once the previous result is taken.
// Synchronous active-low reset returns to idle with the modulus at 257.
`default_nettype none
module modular_line_from_two_points #(
    parameter int VALUE_BITS = mlft_pkg::VALUE_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    mlft_pt_if.sink                             i_pt,
    mlft_res_if.source                          o_res,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mlft_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [mlft_pkg::DATA_W-1:0]    pwdata,
    output logic [mlft_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    localparam int W = VALUE_BITS;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RED    = 4'd1;
    localparam logic [3:0] S_DIFF   = 4'd2;
    localparam logic [3:0] S_EU_CHK = 4'd3;
    localparam logic [3:0] S_EU_DIV = 4'd4;
    localparam logic [3:0] S_EU_MUL = 4'd5;
    localparam logic [3:0] S_GCHK   = 4'd6;
    localparam logic [3:0] S_NDIV   = 4'd7;
    localparam logic [3:0] S_TRED   = 4'd8;
    localparam logic [3:0] S_SMUL   = 4'd9;
    localparam logic [3:0] S_BMUL   = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [mlft_pkg::DATA_W-1:0] r_mod;
    logic [3:0]   r_state;
    logic         r_wait;
    logic [1:0]   r_idx;
    logic [W-1:0] r_v [4];
    logic [W-1:0] r_dy;
    logic [W-1:0] r_r;
    logic [W-1:0] r_nr;
    logic [W-1:0] r_t;
    logic [W-1:0] r_nt;
    logic [W-1:0] r_q;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_dyg;
    logic [W-1:0] r_n;
    logic [W-1:0] r_s;
    logic [W-1:0] r_slope;
    logic [W-1:0] r_icpt;
    logic [1:0]   r_status;

    logic [W-1:0] m;
    mlft_pkg::t_alu_req alu_req;
    logic [W-1:0] alu_a;
    logic [W-1:0] alu_b;
    logic [W-1:0] alu_n;
    logic         alu_done;
    logic [W-1:0] alu_quo;
    logic [W-1:0] alu_rem;
    logic         uses_alu;
    logic         cfg_wr;

    assign m = r_mod[W-1:0];

    // (a - b) mod m for a, b already below m
    function automatic logic [W-1:0] mod_sub(input logic [W-1:0] a, input logic [W-1:0] b,
                                             input logic [W-1:0] md);
        logic [W:0] t;
        logic [W:0] u;
        t = {1'b0, a} + {1'b0, md} - {1'b0, b};
        u = t - {1'b0, md};
        return u[W] ? t[W-1:0] : u[W-1:0];
    endfunction

    always_comb begin
        uses_alu   = 1'b1;
        alu_req.op = mlft_pkg::OP_DIV;
        alu_a      = '0;
        alu_b      = '0;
        alu_n      = m;
        unique case (r_state)
            S_RED: begin
                alu_a = r_v[r_idx];
                alu_b = m;
            end
            S_EU_DIV: begin
                alu_a = r_r;
                alu_b = r_nr;
            end
            S_EU_MUL: begin
                alu_req.op = mlft_pkg::OP_MULMOD;
                alu_a      = r_q;
                alu_b      = r_nt;
            end
            S_GCHK: begin
                alu_a = r_dy;
                alu_b = r_r;
            end
            S_NDIV: begin
                alu_a = m;
                alu_b = r_r;
            end
            S_TRED: begin
                alu_a = r_t;
                alu_b = r_n;
            end
            S_SMUL: begin
                // t reduced modulo n is kept in r_q once the Euclid loop is over
                alu_req.op = mlft_pkg::OP_MULMOD;
                alu_a      = r_dyg;
                alu_b      = r_q;
                alu_n      = r_n;
            end
            S_BMUL: begin
                alu_req.op = mlft_pkg::OP_MULMOD;
                alu_a      = r_v[0];
                alu_b      = r_s;
            end
            default: uses_alu = 1'b0;
        endcase
        alu_req.start = uses_alu && !r_wait;
    end

    mlft_alu #(.W(W)) u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (alu_req),
        .i_a    (alu_a),
        .i_b    (alu_b),
        .i_n    (alu_n),
        .o_done (alu_done),
        .o_quo  (alu_quo),
        .o_rem  (alu_rem)
    );

    assign cfg_wr = psel && penable && pwrite && (paddr == mlft_pkg::ADDR_MODULUS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod   <= mlft_pkg::MODULUS_RST;
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (cfg_wr) begin
                r_mod <= pwdata;
            end
            if (alu_req.start) begin
                r_wait <= 1'b1;
            end else if (alu_done) begin
                r_wait <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_pt.valid) begin
                        r_v[0]  <= i_pt.x_first[W-1:0];
                        r_v[1]  <= i_pt.y_first[W-1:0];
                        r_v[2]  <= i_pt.x_second[W-1:0];
                        r_v[3]  <= i_pt.y_second[W-1:0];
                        r_idx   <= '0;
                        r_slope <= '0;
                        r_icpt  <= '0;
                        if (m < W'(2)) begin
                            r_status <= mlft_pkg::ST_X_EQUAL;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    if (alu_done) begin
                        r_v[r_idx] <= alu_rem;
                        r_idx      <= r_idx + 1'b1;
                        if (r_idx == 2'd3) begin
                            r_state <= S_DIFF;
                        end
                    end
                end
                S_DIFF: begin
                    r_dy <= mod_sub(r_v[1], r_v[3], m);
                    r_r  <= m;
                    r_nr <= mod_sub(r_v[0], r_v[2], m);
                    r_t  <= '0;
                    r_nt <= W'(1);
                    if (r_v[0] == r_v[2]) begin
                        r_status <= mlft_pkg::ST_X_EQUAL;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_EU_CHK;
                    end
                end
                S_EU_CHK: begin
                    r_state <= (r_nr == '0) ? S_GCHK : S_EU_DIV;
                end
                S_EU_DIV: begin
                    if (alu_done) begin
                        r_q     <= alu_quo;
                        r_rem   <= alu_rem;
                        r_state <= S_EU_MUL;
                    end
                end
                S_EU_MUL: begin
                    if (alu_done) begin
                        r_t     <= r_nt;
                        r_nt    <= mod_sub(r_t, alu_rem, m);
                        r_r     <= r_nr;
                        r_nr    <= r_rem;
                        r_state <= S_EU_CHK;
                    end
                end
                S_GCHK: begin
                    if (alu_done) begin
                        if (alu_rem != '0) begin
                            r_status <= mlft_pkg::ST_NO_SLOPE;
                            r_state  <= S_OUT;
                        end else begin
                            r_dyg   <= alu_quo;
                            r_state <= S_NDIV;
                        end
                    end
                end
                S_NDIV: begin
                    if (alu_done) begin
                        r_n <= alu_quo;
                        if (alu_quo < W'(2)) begin
                            r_s     <= '0;
                            r_state <= S_BMUL;
                        end else begin
                            r_state <= S_TRED;
                        end
                    end
                end
                S_TRED: begin
                    if (alu_done) begin
                        r_q     <= alu_rem;
                        r_state <= S_SMUL;
                    end
                end
                S_SMUL: begin
                    if (alu_done) begin
                        r_s     <= alu_rem;
                        r_state <= S_BMUL;
                    end
                end
                S_BMUL: begin
                    if (alu_done) begin
                        r_slope  <= r_s;
                        r_icpt   <= mod_sub(r_v[1], alu_rem, m);
                        r_status <= mlft_pkg::ST_OK;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_res.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_pt.ready      = (r_state == S_IDLE);
    assign o_res.valid     = (r_state == S_OUT);
    assign o_res.slope     = mlft_pkg::DATA_W'(r_slope);
    assign o_res.intercept = mlft_pkg::DATA_W'(r_icpt);
    assign o_res.status    = r_status;
    assign prdata          = (paddr == mlft_pkg::ADDR_MODULUS) ? r_mod : '0;
    assign pready          = 1'b1;
endmodule
`default_nettype wire

// ===== design/mlft_checker.sv =====
// Port-level checks for the line recovery block, bound to the top level.
`default_nettype none
module mlft_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_slope,
    input wire logic [31:0] i_intercept,
    input wire logic [1:0]  i_status
);
    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_slope)
            && $stable(i_intercept) && $stable(i_status))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input taken while a result waits");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready straight after an accepted item");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != mlft_pkg::ST_OK |-> i_slope == 32'd0
            && i_intercept == 32'd0)
        else $error("non-zero result with error status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status <= mlft_pkg::ST_NO_SLOPE)
        else $error("undefined status");
endmodule

bind modular_line_from_two_points mlft_checker u_mlft_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_pt.valid),
    .i_in_ready (i_pt.ready),
    .i_out_valid(o_res.valid),
    .i_out_ready(o_res.ready),
    .i_slope    (o_res.slope),
    .i_intercept(o_res.intercept),
    .i_status   (o_res.status)
);
`default_nettype wire
